// ----- rtl/core/nvs_pkg.sv -----
`default_nettype none

package nvs_pkg;

  // Default storage sizes handed to the top level parameters.
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int MAX_DIM_DEF     = 16;

  // Field widths of the channels.
  localparam int ENTRY_W       = 6;
  localparam int ELEM_W        = 4;
  localparam int SAMPLE_W      = 16;
  localparam int DIST_W        = 36;
  localparam int NUM_ENTRIES_W = 7;
  localparam int VEC_LENGTH_W  = 5;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 7;

  // Widths that cover the whole legal range of the storage parameters
  // (up to 4096 entries and 256 elements).
  localparam int ENTRY_MAX_W = 12;
  localparam int ELEM_MAX_W  = 8;

  // Datapath widths: a difference of two samples and its square.
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int SQ_W   = 2 * SAMPLE_W;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Command codes carried on the command port.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ENTRIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VEC_LENGTH  = 1'b1;

  // One classified transaction waiting for the back.
  typedef struct packed {
    logic                is_query;
    logic [ENTRY_W-1:0]  entry;
    logic [ELEM_W-1:0]   elem;
    logic [SAMPLE_W-1:0] sample;
    logic                trigger;
  } item_t;

  // Scan limits taken from the configuration registers.
  typedef struct packed {
    logic [ELEM_MAX_W-1:0]  last_elem;
    logic [ENTRY_MAX_W-1:0] last_entry;
  } limits_t;

  // Tag that travels with each element through the distance pipeline.
  typedef struct packed {
    logic                   valid;
    logic                   last_elem;
    logic                   last_entry;
    logic [ENTRY_MAX_W-1:0] entry;
  } tag_t;

endpackage

`default_nettype wire

// ----- rtl/core/nvs_ram.sv -----
`default_nettype none

module nvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/nvs_queue.sv -----
`default_nettype none

module nvs_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire nvs_pkg::item_t din,
  output logic               full,
  input  wire logic          pop,
  output nvs_pkg::item_t     dout,
  output logic               empty
);

  nvs_pkg::item_t                 slots [nvs_pkg::QUEUE_DEPTH];
  logic [nvs_pkg::QPTR_W-1:0]     wr_ptr;
  logic [nvs_pkg::QPTR_W-1:0]     rd_ptr;
  logic [nvs_pkg::QPTR_W:0]       count;

  assign full  = (count == (nvs_pkg::QPTR_W + 1)'(nvs_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/nvs_front.sv -----
`default_nettype none

module nvs_front #(
  parameter int MAX_ENTRIES = nvs_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_DIM     = nvs_pkg::MAX_DIM_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             command,
  input  wire logic [nvs_pkg::ENTRY_W-1:0]      entry_index,
  input  wire logic [nvs_pkg::ELEM_W-1:0]       element_index,
  input  wire logic [nvs_pkg::SAMPLE_W-1:0]     sample,
  input  wire logic                             cfg_write,
  input  wire logic [nvs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [nvs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             queue_full,
  output logic                                  push,
  output nvs_pkg::item_t                        item,
  output nvs_pkg::limits_t                      limits
);

  logic [nvs_pkg::NUM_ENTRIES_W-1:0] num_entries;
  logic [nvs_pkg::VEC_LENGTH_W-1:0]  vec_length;
  logic                              accept;
  logic                              elem_ok;
  logic                              entry_ok;
  logic                              is_query;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_entries <= nvs_pkg::NUM_ENTRIES_W'(1);
      vec_length  <= nvs_pkg::VEC_LENGTH_W'(16);
    end else if (cfg_write) begin
      case (cfg_index)
        nvs_pkg::REG_NUM_ENTRIES: num_entries <= cfg_data;
        nvs_pkg::REG_VEC_LENGTH:  vec_length  <= cfg_data[nvs_pkg::VEC_LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero counts as one; values past the storage saturate.
  always_comb begin
    if (vec_length == '0) begin
      limits.last_elem = '0;
    end else if (32'(vec_length) > MAX_DIM) begin
      limits.last_elem = nvs_pkg::ELEM_MAX_W'(MAX_DIM - 1);
    end else begin
      limits.last_elem = nvs_pkg::ELEM_MAX_W'(vec_length - 1'b1);
    end
    if (num_entries == '0) begin
      limits.last_entry = '0;
    end else if (32'(num_entries) > MAX_ENTRIES) begin
      limits.last_entry = nvs_pkg::ENTRY_MAX_W'(MAX_ENTRIES - 1);
    end else begin
      limits.last_entry = nvs_pkg::ENTRY_MAX_W'(num_entries - 1'b1);
    end
  end

  assign busy     = queue_full;
  assign accept   = start && !queue_full;
  assign is_query = (command == nvs_pkg::CMD_QUERY);
  assign elem_ok  = (32'(element_index) < MAX_DIM);
  assign entry_ok = (32'(entry_index) < MAX_ENTRIES);

  // Transactions that address nothing in storage are dropped here.
  assign push = accept && elem_ok && (is_query || entry_ok);

  assign item.is_query = is_query;
  assign item.entry    = entry_index;
  assign item.elem     = element_index;
  assign item.sample   = sample;
  assign item.trigger  = (nvs_pkg::ELEM_MAX_W'(element_index) == limits.last_elem);

endmodule

`default_nettype wire

// ----- rtl/core/nvs_back.sv -----
`default_nettype none

module nvs_back #(
  parameter int MAX_ENTRIES = nvs_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_DIM     = nvs_pkg::MAX_DIM_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire nvs_pkg::item_t               head,
  input  wire logic                         empty,
  output logic                              pop,
  input  wire nvs_pkg::limits_t             limits,
  output logic                              done,
  output logic [nvs_pkg::ENTRY_W-1:0]       nearest_index,
  output logic [nvs_pkg::DIST_W-1:0]        min_distance
);

  localparam int CB_DEPTH = MAX_ENTRIES * MAX_DIM;
  localparam int AW       = (CB_DEPTH > 1) ? $clog2(CB_DEPTH) : 1;
  localparam int KW       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int IW       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ACC_W    = nvs_pkg::SQ_W + ((MAX_DIM > 1) ? $clog2(MAX_DIM) : 0);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t                           state;
  state_t                           state_next;
  logic [KW-1:0]                    k;
  logic [KW-1:0]                    k_next;
  logic [IW-1:0]                    i;
  logic [IW-1:0]                    i_next;
  logic [AW-1:0]                    base;
  logic [AW-1:0]                    base_next;
  logic [KW-1:0]                    last_k;
  logic [IW-1:0]                    last_i;

  logic                             cb_we;
  logic [AW-1:0]                    cb_waddr;
  logic [AW-1:0]                    cb_raddr;
  logic [nvs_pkg::SAMPLE_W-1:0]     cb_rdata;
  logic                             q_we;
  logic [KW-1:0]                    q_waddr;
  logic [nvs_pkg::SAMPLE_W-1:0]     q_rdata;

  nvs_pkg::tag_t                    t0;
  nvs_pkg::tag_t                    t1;
  nvs_pkg::tag_t                    t2;
  nvs_pkg::tag_t                    t3;
  logic signed [nvs_pkg::DIFF_W-1:0]   diff;
  logic signed [2*nvs_pkg::DIFF_W-1:0] prod;
  logic [nvs_pkg::SQ_W-1:0]         sq;
  logic [ACC_W-1:0]                 acc;
  logic [ACC_W-1:0]                 sum;
  logic [ACC_W-1:0]                 best_d;
  logic [IW-1:0]                    best_i;
  logic                             take;

  assign last_k = limits.last_elem[KW-1:0];
  assign last_i = limits.last_entry[IW-1:0];

  // Storage writes happen as queued transactions are retired.
  assign pop      = (state == ST_IDLE) && !empty;
  assign cb_we    = pop && !head.is_query;
  assign cb_waddr = AW'(32'(head.entry) * MAX_DIM + 32'(head.elem));
  assign q_we     = pop && head.is_query;
  assign q_waddr  = KW'(head.elem);
  assign cb_raddr = base + AW'(k);

  nvs_ram #(
    .WIDTH (nvs_pkg::SAMPLE_W),
    .DEPTH (CB_DEPTH)
  ) u_codebook (
    .clk   (clk),
    .we    (cb_we),
    .waddr (cb_waddr),
    .wdata (head.sample),
    .raddr (cb_raddr),
    .rdata (cb_rdata)
  );

  nvs_ram #(
    .WIDTH (nvs_pkg::SAMPLE_W),
    .DEPTH (MAX_DIM)
  ) u_query (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (head.sample),
    .raddr (k),
    .rdata (q_rdata)
  );

  always_comb begin
    state_next = state;
    k_next     = k;
    i_next     = i;
    base_next  = base;
    case (state)
      ST_IDLE: begin
        if (pop && head.is_query && head.trigger) begin
          state_next = ST_SCAN;
          k_next     = '0;
          i_next     = '0;
          base_next  = '0;
        end
      end
      ST_SCAN: begin
        if (k == last_k) begin
          k_next    = '0;
          base_next = base + AW'(MAX_DIM);
          if (i == last_i) begin
            state_next = ST_WAIT;
          end else begin
            i_next = i + 1'b1;
          end
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_WAIT: begin
        if (t3.valid && t3.last_elem && t3.last_entry) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    t0.valid      = (state == ST_SCAN);
    t0.last_elem  = (k == last_k);
    t0.last_entry = (i == last_i);
    t0.entry      = nvs_pkg::ENTRY_MAX_W'(i);
  end

  assign prod = diff * diff;
  assign sum  = acc + ACC_W'(sq);
  assign take = (t3.entry == '0) || (sum < best_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      t1    <= '0;
      t2    <= '0;
      t3    <= '0;
      acc   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      t1    <= t0;
      t2    <= t1;
      t3    <= t2;
      done  <= 1'b0;
      if (t3.valid) begin
        if (t3.last_elem) begin
          acc <= '0;
          done <= t3.last_entry;
        end else begin
          acc <= sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    k    <= k_next;
    i    <= i_next;
    base <= base_next;
    diff <= $signed({cb_rdata[nvs_pkg::SAMPLE_W-1], cb_rdata})
          - $signed({q_rdata[nvs_pkg::SAMPLE_W-1], q_rdata});
    sq   <= prod[nvs_pkg::SQ_W-1:0];
    if (t3.valid && t3.last_elem) begin
      if (take) begin
        best_d <= sum;
        best_i <= t3.entry[IW-1:0];
      end
      if (t3.last_entry) begin
        nearest_index <= take ? nvs_pkg::ENTRY_W'(t3.entry) : nvs_pkg::ENTRY_W'(best_i);
        min_distance  <= take ? nvs_pkg::DIST_W'(sum) : nvs_pkg::DIST_W'(best_d);
      end
    end
  end

`ifndef SYNTH
  a_done_ends_search: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_WAIT)) else $error("result outside a search");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !(t1.valid || t2.valid || t3.valid))
    else $error("distance pipeline busy while idle");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/nearest_vector_search.sv -----
`default_nettype none

// Channel      Direction  Handshake              Payload
// command in   input      start, busy            command, entry_index, element_index, sample
// result out   output     done (one-cycle pulse) nearest_index, min_distance
// config       input      cfg_write              cfg_index, cfg_data
//
// A transaction is taken at a rising edge with start high and busy low. It
// enters a four-deep command queue, so busy only rises when that queue is full.
// A load is written to the codebook as it leaves the queue. A query element
// that completes the vector starts a search that passes every active element
// through the read, difference, square and accumulate stages; the single
// codebook read port and the one multiply-accumulate lane take them in turn.
// Reset is synchronous and needs no clearing pass: the codebook and query
// storage hold whatever they held until they are written.
// The result is shown on done for exactly one cycle and the receiver cannot
// stall it.
module nearest_vector_search #(
  parameter int MAX_ENTRIES = nvs_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_DIM     = nvs_pkg::MAX_DIM_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             command,
  input  wire logic [nvs_pkg::ENTRY_W-1:0]      entry_index,
  input  wire logic [nvs_pkg::ELEM_W-1:0]       element_index,
  input  wire logic [nvs_pkg::SAMPLE_W-1:0]     sample,
  input  wire logic                             cfg_write,
  input  wire logic [nvs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [nvs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                  done,
  output logic [nvs_pkg::ENTRY_W-1:0]           nearest_index,
  output logic [nvs_pkg::DIST_W-1:0]            min_distance
);

  // Classified transactions pass from the front through the queue to the back.
  logic             push;
  logic             pop;
  logic             queue_full;
  logic             queue_empty;
  nvs_pkg::item_t   item_in;
  nvs_pkg::item_t   item_head;
  nvs_pkg::limits_t limits;

  // The front holds the configuration registers, checks each transaction
  // against the storage bounds and marks the query element that starts a
  // search.
  nvs_front #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_DIM     (MAX_DIM)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .entry_index   (entry_index),
    .element_index (element_index),
    .sample        (sample),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .queue_full    (queue_full),
    .push          (push),
    .item          (item_in),
    .limits        (limits)
  );

  // The queue keeps loads and queries in order, so a load that arrives
  // during a search is written only after that search has read the codebook.
  nvs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (item_in),
    .full  (queue_full),
    .pop   (pop),
    .dout  (item_head),
    .empty (queue_empty)
  );

  // The back owns both memories and the distance pipeline. Ties keep the
  // lower entry because only a strictly smaller distance replaces the best.
  nvs_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_DIM     (MAX_DIM)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (item_head),
    .empty         (queue_empty),
    .pop           (pop),
    .limits        (limits),
    .done          (done),
    .nearest_index (nearest_index),
    .min_distance  (min_distance)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nvs_pkg::*;

  // Storage shape of the block as instantiated with its default parameters.
  localparam int CB_ENTRIES = MAX_ENTRIES_DEF;
  localparam int CB_DIM     = MAX_DIM_DEF;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;

  // Random settings keep entries times elements at or below this figure, so
  // that one search never grows long. Each register still reaches both of
  // its extremes, just not both at once.
  localparam int SEARCH_CAP = 256;

  // Cycles allowed after the last expected result before the block counts
  // as idle: the four-deep command queue can still hold loads and query
  // elements that retire without a result.
  localparam int SETTLE_CYCLES = 16;

  // Watchdog. About 1650 transactions, each at worst a full capped search
  // plus the sender's longest gaps, still come to well under this limit.
  localparam longint CYCLE_LIMIT = 2_000_000;

  // One search outcome as it appears on the result ports.
  typedef struct packed {
    logic [ENTRY_W-1:0] index;
    logic [DIST_W-1:0]  distance;
  } match_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  command = CMD_LOAD;
  logic [ENTRY_W-1:0]    entry_index = '0;
  logic [ELEM_W-1:0]     element_index = '0;
  logic [SAMPLE_W-1:0]   sample = '0;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_NUM_ENTRIES;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  busy;
  logic                  done;
  logic [ENTRY_W-1:0]    nearest_index;
  logic [DIST_W-1:0]     min_distance;

  // Shadow copy of the block's storage and registers. The written flags
  // keep the stimulus from ever reading an element that holds no value yet.
  logic signed [SAMPLE_W-1:0] codebook_mem [CB_ENTRIES][CB_DIM];
  logic signed [SAMPLE_W-1:0] query_mem [CB_DIM];
  bit                         codebook_written [CB_ENTRIES][CB_DIM];
  bit                         query_written [CB_DIM];
  logic [NUM_ENTRIES_W-1:0]   num_entries_reg = 7'd1;
  logic [VEC_LENGTH_W-1:0]    vec_length_reg = 5'd16;

  match_t expected_matches [$];
  int     error_count = 0;
  int     items_sent = 0;
  int     sender_idle_pct = 0;
  longint cycle_count = 0;

  nearest_vector_search dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .entry_index   (entry_index),
    .element_index (element_index),
    .sample        (sample),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .nearest_index (nearest_index),
    .min_distance  (min_distance)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A zero count searches one entry; counts past the storage saturate.
  function automatic int entries_in_use(input logic [NUM_ENTRIES_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > CB_ENTRIES) return CB_ENTRIES;
    return int'(raw);
  endfunction

  // Same rule for the vector length.
  function automatic int length_in_use(input logic [VEC_LENGTH_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > CB_DIM) return CB_DIM;
    return int'(raw);
  endfunction

  // Full scan of the active codebook against the shadow query vector. The
  // strict less-than keeps the lowest index when two distances are equal.
  function automatic match_t search_codebook();
    match_t           best;
    longint unsigned  sum;
    longint           diff;
    int               n;
    int               len;
    n = entries_in_use(num_entries_reg);
    len = length_in_use(vec_length_reg);
    best = '0;
    for (int e = 0; e < n; e++) begin
      sum = 0;
      for (int k = 0; k < len; k++) begin
        diff = longint'(codebook_mem[e][k]) - longint'(query_mem[k]);
        sum += longint'(diff * diff);
      end
      if (e == 0 || sum < best.distance) begin
        best.index = ENTRY_W'(e);
        best.distance = DIST_W'(sum);
      end
    end
    return best;
  endfunction

  // Updates the shadow state for one accepted transaction. Only the query
  // element at the last active position starts a search.
  function automatic void apply_item(input logic cmd, input logic [ENTRY_W-1:0] entry,
                                     input logic [ELEM_W-1:0] elem,
                                     input logic [SAMPLE_W-1:0] value);
    if (cmd == CMD_LOAD) begin
      codebook_mem[entry][elem] = value;
      codebook_written[entry][elem] = 1'b1;
    end else begin
      query_mem[elem] = value;
      query_written[elem] = 1'b1;
      if (elem == length_in_use(vec_length_reg) - 1)
        expected_matches.push_back(search_codebook());
    end
  endfunction

  // Samples lean on the two extremes and on a narrow band around zero, where
  // equal distances, and so ties, are common.
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2, 3: return SAMPLE_W'($urandom_range(0, 6) - 3);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic hold_off();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Presents one transaction, after a random gap, and holds it until the
  // block takes it. The shadow state moves at the accepting edge.
  task automatic send_item(input logic cmd, input logic [ENTRY_W-1:0] entry,
                           input logic [ELEM_W-1:0] elem, input logic [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < sender_idle_pct)
      hold_off();
    @(negedge clk);
    start <= 1'b1;
    command <= cmd;
    entry_index <= entry;
    element_index <= elem;
    sample <= value;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    apply_item(cmd, entry, elem, value);
    items_sent++;
  endtask

  // Sends a transaction. Before a query element that would start a search,
  // every codebook element and query element that the search reads and
  // that still holds no value is written first.
  task automatic issue(input logic cmd, input logic [ENTRY_W-1:0] entry,
                       input logic [ELEM_W-1:0] elem, input logic [SAMPLE_W-1:0] value);
    int n;
    int len;
    n = entries_in_use(num_entries_reg);
    len = length_in_use(vec_length_reg);
    if (cmd == CMD_QUERY && elem == len - 1) begin
      for (int e = 0; e < n; e++)
        for (int k = 0; k < len; k++)
          if (!codebook_written[e][k])
            send_item(CMD_LOAD, ENTRY_W'(e), ELEM_W'(k), rand_sample());
      for (int k = 0; k < len - 1; k++)
        if (!query_written[k])
          send_item(CMD_QUERY, ENTRY_W'($urandom), ELEM_W'(k), rand_sample());
    end
    send_item(cmd, entry, elem, value);
  endtask

  // Stops sending and waits until every search has reported, then lets the
  // queue retire whatever transactions produce no result.
  task automatic wait_for_results();
    hold_off();
    while (expected_matches.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_NUM_ENTRIES)
      num_entries_reg = data[NUM_ENTRIES_W-1:0];
    else
      vec_length_reg = data[VEC_LENGTH_W-1:0];
  endtask

  // Picks a new pair of register values, out-of-range ones included, and
  // writes both once the block has drained. The upper data bits above the
  // length register are randomized as well, since the block drops them.
  task automatic reconfigure();
    logic [CFG_DATA_W-1:0] n_data;
    logic [CFG_DATA_W-1:0] v_data;
    do begin
      case ($urandom_range(5))
        0: n_data = CFG_DATA_W'($urandom_range(0, 1));
        1: n_data = CFG_DATA_W'($urandom_range(64, 127));
        2: n_data = CFG_DATA_W'($urandom_range(1, 4));
        default: n_data = CFG_DATA_W'($urandom_range(1, 16));
      endcase
      case ($urandom_range(4))
        0: v_data = CFG_DATA_W'($urandom_range(0, 1));
        1: v_data = CFG_DATA_W'($urandom_range(16, 31));
        2: v_data = CFG_DATA_W'($urandom_range(0, 127));
        default: v_data = CFG_DATA_W'($urandom_range(1, 8));
      endcase
    end while (entries_in_use(n_data[NUM_ENTRIES_W-1:0]) *
               length_in_use(v_data[VEC_LENGTH_W-1:0]) > SEARCH_CAP);
    wait_for_results();
    write_register(REG_NUM_ENTRIES, n_data);
    write_register(REG_VEC_LENGTH, v_data);
  endtask

  // With the registers at their reset values (one entry, sixteen elements),
  // the entry holds the largest sample everywhere and the query the smallest,
  // which gives the largest distance the block can produce.
  task automatic test_power_on_defaults();
    sender_idle_pct = 0;
    for (int k = 0; k < CB_DIM; k++)
      issue(CMD_LOAD, '0, ELEM_W'(k), SAMPLE_MAX);
    for (int k = 0; k < CB_DIM; k++)
      issue(CMD_QUERY, '1, ELEM_W'(k), SAMPLE_MIN);
  endtask

  // Three entries of two elements, where entries one and two are equally
  // close: the lower index has to win. A query element past the active
  // length is stored but starts nothing. The last trigger is followed at
  // once by a load that must not leak into the search already under way,
  // and a further trigger then sees the new value.
  task automatic test_tie_keeps_lowest();
    wait_for_results();
    write_register(REG_NUM_ENTRIES, CFG_DATA_W'(3));
    write_register(REG_VEC_LENGTH, CFG_DATA_W'(2));
    issue(CMD_LOAD, 6'd0, 4'd0, 16'd100);
    issue(CMD_LOAD, 6'd0, 4'd1, 16'd100);
    issue(CMD_LOAD, 6'd1, 4'd0, -16'sd3);
    issue(CMD_LOAD, 6'd1, 4'd1, 16'd7);
    issue(CMD_LOAD, 6'd2, 4'd0, -16'sd3);
    issue(CMD_LOAD, 6'd2, 4'd1, 16'd7);
    issue(CMD_QUERY, 6'd0, 4'd9, SAMPLE_MIN);
    issue(CMD_QUERY, 6'd0, 4'd0, -16'sd1);
    issue(CMD_QUERY, 6'd0, 4'd1, 16'd5);
    issue(CMD_LOAD, 6'd1, 4'd0, -16'sd1);
    issue(CMD_QUERY, 6'd63, 4'd1, 16'd5);
  endtask

  // Random searches. Most of the traffic is whole query sequences with a
  // few codebook updates in front, elements in random subsets and the
  // triggering element last; one in five transactions is free noise with
  // every field random. The registers change now and then, always after a
  // drain, and the sender sometimes stops until all results are in.
  task automatic test_random_searches(input int idle_pct, input int item_count);
    int stop_at;
    int n;
    int len;
    sender_idle_pct = idle_pct;
    stop_at = items_sent + item_count;
    reconfigure();
    while (items_sent < stop_at) begin
      if ($urandom_range(9) == 0)
        reconfigure();
      else if ($urandom_range(29) == 0)
        wait_for_results();
      n = entries_in_use(num_entries_reg);
      len = length_in_use(vec_length_reg);
      if ($urandom_range(4) == 0) begin
        issue(1'($urandom), ENTRY_W'($urandom), ELEM_W'($urandom), rand_sample());
      end else begin
        repeat ($urandom_range(0, 3))
          issue(CMD_LOAD, ENTRY_W'($urandom_range(0, n - 1)),
                ELEM_W'($urandom_range(0, len - 1)), rand_sample());
        for (int k = 0; k < len - 1; k++)
          if ($urandom_range(1) != 0)
            issue(CMD_QUERY, ENTRY_W'($urandom), ELEM_W'(k), rand_sample());
        issue(CMD_QUERY, ENTRY_W'($urandom), ELEM_W'(len - 1), rand_sample());
      end
    end
  endtask

  // Every result strobe is matched against the oldest outstanding search.
  always @(posedge clk) begin : check_result
    match_t want;
    if (!rst && done) begin
      if (expected_matches.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, got index %0d distance %0d",
                 $time, nearest_index, min_distance);
      end else begin
        want = expected_matches.pop_front();
        if (nearest_index !== want.index) begin
          error_count++;
          $display("%0t: nearest_index mismatch: expected %0d, got %0d",
                   $time, want.index, nearest_index);
        end
        if (min_distance !== want.distance) begin
          error_count++;
          $display("%0t: min_distance mismatch: expected %0d, got %0d",
                   $time, want.distance, min_distance);
        end
      end
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_power_on_defaults();
    test_tie_keeps_lowest();
    test_random_searches(38, 550);
    test_random_searches(68, 550);
    test_random_searches(0, 550);

    // Any result still owed must arrive, and nothing extra may follow it.
    wait_for_results();
    if (expected_matches.size() != 0)
      error_count++;
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
